// File: hw/rtl/scaled_sprite_blitter_assert.svh
// Assertion macros shared by the blitter's checker.
// Each macro expands to one labeled concurrent assertion on clock aclk.
`ifndef SCALED_SPRITE_BLITTER_ASSERT_SVH
`define SCALED_SPRITE_BLITTER_ASSERT_SVH

// Antecedent at one edge, consequent at the next, outside reset.
`define SSB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// What a cycle in reset leaves behind at the following edge.
`define SSB_ASSERT_RST(lbl, cons, msg) \
    lbl: assert property (@(posedge aclk) !aresetn |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/ssb_pkg.sv
// Shared types and constants of the scaled sprite blitter.
// Used by every module of the block; depends on nothing.
package ssb_pkg;

    localparam int SPRITE_MAX  = 32;
    localparam int SCALE_MAX   = 8;
    localparam int CANVAS_MAX  = 1024;
    localparam int QUEUE_DEPTH = 4;

    localparam int COLOR_W    = 16;
    localparam int ADDR_W     = 20;
    localparam int CFG_DATA_W = 11;
    localparam int ORG_W      = 11;
    localparam int CANVAS_F_W = 11;
    localparam int SIZE_F_W   = 6;
    localparam int SCALE_F_W  = 4;

    localparam int POS_W    = (SPRITE_MAX > 1) ? $clog2(SPRITE_MAX) : 1;
    localparam int SIZE_W   = $clog2(SPRITE_MAX + 1);
    localparam int SCALE_W  = $clog2(SCALE_MAX + 1);
    localparam int CANVAS_W = $clog2(CANVAS_MAX + 1);
    localparam int XY_W     = (CANVAS_MAX > 1) ? $clog2(CANVAS_MAX) : 1;
    localparam int G_W      = 14;

    localparam int RST_WIDTH  = 320;
    localparam int RST_HEIGHT = 240;
    localparam int RST_SIZE   = 32;
    localparam int RST_SCALE  = 1;

    typedef enum logic [2:0] {
        REG_CANVAS_WIDTH  = 3'd0,
        REG_CANVAS_HEIGHT = 3'd1,
        REG_ORIGIN_X      = 3'd2,
        REG_ORIGIN_Y      = 3'd3,
        REG_SPRITE_SIZE   = 3'd4,
        REG_SCALE_FACTOR  = 3'd5,
        REG_CENTRED       = 3'd6
    } cfg_index_t;

    // Configuration as held, already clamped to legal ranges.
    typedef struct packed {
        logic [CANVAS_W-1:0]     width;
        logic [CANVAS_W-1:0]     height;
        logic signed [ORG_W-1:0] org_x;
        logic signed [ORG_W-1:0] org_y;
        logic [SIZE_W-1:0]       size;
        logic [SCALE_W-1:0]      scale;
        logic                    centred;
    } cfg_t;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               opaque;
    } pix_in_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  address;
        logic [COLOR_W-1:0] pixel;
        logic               last;
    } pix_out_t;

    // Clipped write block: top-left canvas position and extent.
    typedef struct packed {
        logic [XY_W-1:0]    gx;
        logic [XY_W-1:0]    gy;
        logic [SCALE_W-1:0] cnt_x;
        logic [SCALE_W-1:0] cnt_y;
        logic [COLOR_W-1:0] color;
    } cmd_t;

endpackage

// File: hw/rtl/ssb_front.sv
// Front end: source position tracking, block placement and clipping.
// Uses ssb_pkg; feeds clipped write blocks to the command queue.
module ssb_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  ssb_pkg::cfg_t    cfg,
    input  logic             s_valid,
    output logic             s_ready,
    input  ssb_pkg::pix_in_t s_data,
    output logic             cmd_valid,
    input  logic             cmd_ready,
    output ssb_pkg::cmd_t    cmd_data
);
    import ssb_pkg::*;

    localparam int CMP_W = SIZE_W + 1;

    typedef struct packed {
        logic               ok;
        logic [XY_W-1:0]    start;
        logic [SCALE_W-1:0] cnt;
    } axis_t;

    function automatic axis_t clip_axis(logic signed [G_W-1:0] g0,
                                        logic [CANVAS_W-1:0] lim,
                                        logic [SCALE_W-1:0] k);
        logic signed [G_W-1:0] g_end;
        logic signed [G_W-1:0] lim_m1;
        logic signed [G_W-1:0] lo_c;
        logic signed [G_W-1:0] hi_c;
        logic signed [G_W-1:0] span;
        axis_t r;
        g_end  = g0 + $signed(G_W'(k)) - $signed(G_W'(1));
        lim_m1 = $signed(G_W'(lim)) - $signed(G_W'(1));
        lo_c   = (g0 < 0) ? '0 : g0;
        hi_c   = (g_end > lim_m1) ? lim_m1 : g_end;
        span   = hi_c - lo_c + $signed(G_W'(1));
        r.ok    = (hi_c >= lo_c);
        r.start = XY_W'(lo_c);
        r.cnt   = SCALE_W'(span);
        return r;
    endfunction

    logic [POS_W-1:0] col_reg, row_reg, col_next, row_next;
    logic [POS_W-1:0] col_eff, row_eff;
    logic             s_fire;

    logic [SIZE_W+SCALE_W-1:0] nk;
    logic [POS_W+SCALE_W-1:0]  colk, rowk;
    logic signed [G_W-1:0]     half_s, gx0, gy0;

    logic                  a_vld_reg;
    logic signed [G_W-1:0] a_gx_reg, a_gy_reg;
    logic [COLOR_W-1:0]    a_color_reg;
    logic                  a_adv;
    axis_t                 ax, ay;

    assign s_fire = s_valid && s_ready;

    always_comb begin
        // A position left beyond a shrunken sprite restarts at zero.
        col_eff = (CMP_W'(col_reg) >= CMP_W'(cfg.size)) ? '0 : col_reg;
        row_eff = (CMP_W'(row_reg) >= CMP_W'(cfg.size)) ? '0 : row_reg;
        if (CMP_W'(col_eff) + CMP_W'(1) >= CMP_W'(cfg.size)) begin
            col_next = '0;
            row_next = (CMP_W'(row_eff) + CMP_W'(1) >= CMP_W'(cfg.size)) ? '0
                     : POS_W'(row_eff + POS_W'(1));
        end else begin
            col_next = POS_W'(col_eff + POS_W'(1));
            row_next = row_eff;
        end
    end

    always_comb begin
        nk     = (SIZE_W+SCALE_W)'(cfg.size) * (SIZE_W+SCALE_W)'(cfg.scale);
        colk   = (POS_W+SCALE_W)'(col_eff) * (POS_W+SCALE_W)'(cfg.scale);
        rowk   = (POS_W+SCALE_W)'(row_eff) * (POS_W+SCALE_W)'(cfg.scale);
        half_s = cfg.centred ? $signed(G_W'(nk >> 1)) : '0;
        gx0    = G_W'($signed(cfg.org_x)) - half_s + $signed(G_W'(colk));
        gy0    = G_W'($signed(cfg.org_y)) - half_s + $signed(G_W'(rowk));
    end

    always_comb begin
        ax = clip_axis(a_gx_reg, cfg.width, cfg.scale);
        ay = clip_axis(a_gy_reg, cfg.height, cfg.scale);
        cmd_valid = a_vld_reg && ax.ok && ay.ok;
        // Drop a block that lies wholly off the canvas without a queue slot.
        a_adv     = a_vld_reg && (!(ax.ok && ay.ok) || cmd_ready);
        s_ready   = !a_vld_reg || a_adv;
        cmd_data  = '{gx: ax.start, gy: ay.start, cnt_x: ax.cnt, cnt_y: ay.cnt,
                      color: a_color_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            row_reg   <= '0;
            a_vld_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (s_fire && s_data.opaque) begin
                a_vld_reg <= 1'b1;
            end else if (a_adv) begin
                a_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && s_data.opaque) begin
            a_gx_reg    <= gx0;
            a_gy_reg    <= gy0;
            a_color_reg <= s_data.color;
        end
    end

endmodule

// File: hw/rtl/ssb_queue.sv
// Short command queue between front and back end.
// Uses ssb_pkg for the command type and depth.
module ssb_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  ssb_pkg::cmd_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output ssb_pkg::cmd_t out_data
);
    import ssb_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                            : PTR_W'(wr_ptr_reg + PTR_W'(1));
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                            : PTR_W'(rd_ptr_reg + PTR_W'(1));
            end
            if (push && !pop) begin
                count_reg <= CNT_W'(count_reg + CNT_W'(1));
            end else if (pop && !push) begin
                count_reg <= CNT_W'(count_reg - CNT_W'(1));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// File: hw/rtl/ssb_back.sv
// Back end: row base address, write walker over a clipped block, output register.
// Uses ssb_pkg; takes commands from the queue and drives the write channel.
module ssb_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  ssb_pkg::cfg_t     cfg,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  ssb_pkg::cmd_t     cmd_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ssb_pkg::pix_out_t m_data
);
    import ssb_pkg::*;

    localparam int PROD_W = XY_W + CANVAS_W + 1;

    logic [PROD_W-1:0]  base_full;

    logic               p_vld_reg;
    logic [ADDR_W-1:0]  p_base_reg;
    logic [SCALE_W-1:0] p_cnt_x_reg, p_cnt_y_reg;
    logic [COLOR_W-1:0] p_color_reg;

    logic               w_act_reg;
    logic [ADDR_W-1:0]  w_addr_reg, w_row_reg, w_row_next;
    logic [SCALE_W-1:0] w_dx_reg, w_dy_reg, w_cnt_x_reg, w_cnt_y_reg;
    logic [COLOR_W-1:0] w_color_reg;

    logic               m_valid_reg;
    pix_out_t           m_data_reg;

    logic out_take, w_step, x_last, y_last, w_done, w_load, p_load;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        base_full  = PROD_W'(cmd_data.gy) * PROD_W'(cfg.width) + PROD_W'(cmd_data.gx);
        w_row_next = ADDR_W'(w_row_reg + ADDR_W'(cfg.width));
        out_take   = !m_valid_reg || m_ready;
        w_step     = w_act_reg && out_take;
        x_last     = (SCALE_W'(w_dx_reg + SCALE_W'(1)) == w_cnt_x_reg);
        y_last     = (SCALE_W'(w_dy_reg + SCALE_W'(1)) == w_cnt_y_reg);
        w_done     = w_step && x_last && y_last;
        // Reload the walker in the cycle its last write goes out.
        w_load     = p_vld_reg && (!w_act_reg || w_done);
        cmd_ready  = !p_vld_reg || w_load;
        p_load     = cmd_valid && cmd_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_vld_reg   <= 1'b0;
            w_act_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (p_load) begin
                p_vld_reg <= 1'b1;
            end else if (w_load) begin
                p_vld_reg <= 1'b0;
            end
            if (w_load) begin
                w_act_reg <= 1'b1;
            end else if (w_done) begin
                w_act_reg <= 1'b0;
            end
            if (w_step) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (p_load) begin
            p_base_reg  <= ADDR_W'(base_full);
            p_cnt_x_reg <= cmd_data.cnt_x;
            p_cnt_y_reg <= cmd_data.cnt_y;
            p_color_reg <= cmd_data.color;
        end
        if (w_load) begin
            w_addr_reg  <= p_base_reg;
            w_row_reg   <= p_base_reg;
            w_dx_reg    <= '0;
            w_dy_reg    <= '0;
            w_cnt_x_reg <= p_cnt_x_reg;
            w_cnt_y_reg <= p_cnt_y_reg;
            w_color_reg <= p_color_reg;
        end else if (w_step) begin
            if (x_last) begin
                w_dx_reg   <= '0;
                w_dy_reg   <= SCALE_W'(w_dy_reg + SCALE_W'(1));
                w_row_reg  <= w_row_next;
                w_addr_reg <= w_row_next;
            end else begin
                w_dx_reg   <= SCALE_W'(w_dx_reg + SCALE_W'(1));
                w_addr_reg <= ADDR_W'(w_addr_reg + ADDR_W'(1));
            end
        end
        if (w_step) begin
            m_data_reg <= '{address: w_addr_reg, pixel: w_color_reg,
                            last: x_last && y_last};
        end
    end

endmodule

// File: hw/rtl/scaled_sprite_blitter.sv
// Scaled sprite blitter top level: configuration registers, front end, queue, back end.
// The back-end walker makes one canvas write per cycle while m_ready does not stall it;
// an opaque pixel yields as many writes as survive clipping (scale squared, 64 at most).
// Transparent or fully clipped pixels are taken one per cycle while the front end is not
// held by a block waiting for a queue slot, and cost no write slot.
// Reset (aresetn low, synchronous) clears position, queue and pipeline; registers default.
module scaled_sprite_blitter (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  ssb_pkg::pix_in_t            s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output ssb_pkg::pix_out_t           m_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  ssb_pkg::cfg_index_t         cfg_index,
    input  logic [ssb_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ssb_pkg::*;

    cfg_t cfg_reg;
    logic cmd_f_valid, cmd_f_ready, cmd_b_valid, cmd_b_ready;
    cmd_t cmd_f_data, cmd_b_data;

    logic [CANVAS_F_W-1:0] raw_canvas;
    logic [SIZE_F_W-1:0]   raw_size;
    logic [SCALE_F_W-1:0]  raw_scale;
    logic [CANVAS_W-1:0]   canvas_clamped;
    logic [SIZE_W-1:0]     size_clamped;
    logic [SCALE_W-1:0]    scale_clamped;

    assign cfg_ready = 1'b1;

    always_comb begin
        raw_canvas = cfg_data[CANVAS_F_W-1:0];
        raw_size   = cfg_data[SIZE_F_W-1:0];
        raw_scale  = cfg_data[SCALE_F_W-1:0];
        // Zero acts as one, anything above the maximum as the maximum.
        if (raw_canvas == '0) begin
            canvas_clamped = CANVAS_W'(1);
        end else if (raw_canvas > CANVAS_MAX) begin
            canvas_clamped = CANVAS_W'(CANVAS_MAX);
        end else begin
            canvas_clamped = CANVAS_W'(raw_canvas);
        end
        if (raw_size == '0) begin
            size_clamped = SIZE_W'(1);
        end else if (raw_size > SPRITE_MAX) begin
            size_clamped = SIZE_W'(SPRITE_MAX);
        end else begin
            size_clamped = SIZE_W'(raw_size);
        end
        if (raw_scale == '0) begin
            scale_clamped = SCALE_W'(1);
        end else if (raw_scale > SCALE_MAX) begin
            scale_clamped = SCALE_W'(SCALE_MAX);
        end else begin
            scale_clamped = SCALE_W'(raw_scale);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.width   <= CANVAS_W'(RST_WIDTH);
            cfg_reg.height  <= CANVAS_W'(RST_HEIGHT);
            cfg_reg.org_x   <= '0;
            cfg_reg.org_y   <= '0;
            cfg_reg.size    <= SIZE_W'(RST_SIZE);
            cfg_reg.scale   <= SCALE_W'(RST_SCALE);
            cfg_reg.centred <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_CANVAS_WIDTH:  cfg_reg.width   <= canvas_clamped;
                REG_CANVAS_HEIGHT: cfg_reg.height  <= canvas_clamped;
                REG_ORIGIN_X:      cfg_reg.org_x   <= $signed(cfg_data[ORG_W-1:0]);
                REG_ORIGIN_Y:      cfg_reg.org_y   <= $signed(cfg_data[ORG_W-1:0]);
                REG_SPRITE_SIZE:   cfg_reg.size    <= size_clamped;
                REG_SCALE_FACTOR:  cfg_reg.scale   <= scale_clamped;
                REG_CENTRED:       cfg_reg.centred <= cfg_data[0];
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    ssb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (cmd_f_valid),
        .cmd_ready (cmd_f_ready),
        .cmd_data  (cmd_f_data)
    );

    ssb_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cmd_f_valid),
        .in_ready  (cmd_f_ready),
        .in_data   (cmd_f_data),
        .out_valid (cmd_b_valid),
        .out_ready (cmd_b_ready),
        .out_data  (cmd_b_data)
    );

    ssb_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_b_valid),
        .cmd_ready (cmd_b_ready),
        .cmd_data  (cmd_b_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// File: hw/rtl/ssb_checker.sv
// Port-level checker for the scaled sprite blitter, bound to the top level.
// Uses ssb_pkg and the macros of scaled_sprite_blitter_assert.svh.
`include "scaled_sprite_blitter_assert.svh"

module ssb_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input ssb_pkg::pix_out_t           m_data
);
    import ssb_pkg::*;

    // A stalled write holds.
    `SSB_ASSERT_NXT(a_m_hold, m_valid && !m_ready, m_valid && $stable(m_data), "write changed while stalled")
    // Writes of one block go out back to back once the first is taken.
    `SSB_ASSERT_NXT(a_block_burst, m_valid && m_ready && !m_data.last, m_valid, "gap inside a write block")
    // Input is open again right after a reset cycle.
    `SSB_ASSERT_RST(a_reset_ready, s_ready, "input blocked after reset")
    `SSB_ASSERT_RST(a_reset_idle, !m_valid, "write valid after reset")

endmodule

bind scaled_sprite_blitter ssb_checker u_ssb_checker (.*);

// File: verif/scaled_sprite_blitter_test.sv
// Self-checking testbench for scaled_sprite_blitter: directed sprite cases, then random sprites.
// Depends on ssb_pkg and the blitter RTL; predicts every canvas write and checks it in order.
module scaled_sprite_blitter_test;
    import ssb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY      = 5;
    localparam int SETTLE       = 4 * LATENCY + 4;
    localparam int IDLE_LIMIT   = 4000;
    localparam int RANDOM_ITEMS = 340;
    localparam int PRINT_CAP    = 40;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    pix_in_t    s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    pix_out_t   m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    cfg_index_t cfg_index = REG_CANVAS_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    scaled_sprite_blitter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Register copies, raw as written; clamping happens at prediction time.
    logic [10:0]       cfg_width   = 11'd320;
    logic [10:0]       cfg_height  = 11'd240;
    logic signed [10:0] cfg_org_x  = '0;
    logic signed [10:0] cfg_org_y  = '0;
    logic [5:0]        cfg_size    = 6'd32;
    logic [3:0]        cfg_scale   = 4'd1;
    logic              cfg_centred = 1'b0;

    int src_col = 0;
    int src_row = 0;

    pix_out_t pending_writes[$];
    int errors = 0;
    int burst_left = 0;
    bit gaps_on = 1'b1;

    function automatic int clamp_to(int v, int hi);
        return (v < 1) ? 1 : ((v > hi) ? hi : v);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (errors < PRINT_CAP)
            $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
        errors++;
    endtask

    // Expand one source pixel into its clipped block of canvas writes, then advance.
    task automatic blit_pixel(input pix_in_t px);
        int n, k, w, h, x0, y0, gx, gy, first, idx;
        pix_out_t wr;
        n = clamp_to(int'(cfg_size), SPRITE_MAX);
        k = clamp_to(int'(cfg_scale), SCALE_MAX);
        w = clamp_to(int'(cfg_width), CANVAS_MAX);
        h = clamp_to(int'(cfg_height), CANVAS_MAX);
        x0 = int'(cfg_org_x);
        y0 = int'(cfg_org_y);
        if (src_col >= n) src_col = 0;
        if (src_row >= n) src_row = 0;
        if (cfg_centred) begin
            x0 -= (n * k) / 2;
            y0 -= (n * k) / 2;
        end
        if (px.opaque) begin
            first = pending_writes.size();
            for (int dy = 0; dy < k; dy++) begin
                gy = y0 + src_row * k + dy;
                if (gy < 0 || gy >= h) continue;
                for (int dx = 0; dx < k; dx++) begin
                    gx = x0 + src_col * k + dx;
                    if (gx < 0 || gx >= w) continue;
                    wr.address = ADDR_W'(gy * w + gx);
                    wr.pixel   = px.color;
                    wr.last    = 1'b0;
                    pending_writes.push_back(wr);
                end
            end
            if (pending_writes.size() > first) begin
                idx = pending_writes.size() - 1;
                wr = pending_writes[idx];
                wr.last = 1'b1;
                pending_writes[idx] = wr;
            end
        end
        if (src_col + 1 >= n) begin
            src_col = 0;
            src_row = (src_row + 1 >= n) ? 0 : src_row + 1;
        end else begin
            src_col = src_col + 1;
        end
    endtask

    task automatic send_pixel(input pix_in_t px);
        if (gaps_on && burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0) burst_left--;
        s_valid <= 1'b1;
        s_data  <= px;
        do @(posedge aclk); while (!s_ready);
        blit_pixel(px);
    endtask

    task automatic send_color(input logic [15:0] color, input logic opaque);
        pix_in_t px;
        px.color  = color;
        px.opaque = opaque;
        send_pixel(px);
    endtask

    // Hold requests until every predicted write has come out.
    task automatic wait_for_writes();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending_writes.size() != 0) @(posedge aclk);
    endtask

    // Drain, then let transparent requests still in flight retire.
    task automatic settle_block();
        wait_for_writes();
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [10:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_CANVAS_WIDTH:  cfg_width   = val;
            REG_CANVAS_HEIGHT: cfg_height  = val;
            REG_ORIGIN_X:      cfg_org_x   = val;
            REG_ORIGIN_Y:      cfg_org_y   = val;
            REG_SPRITE_SIZE:   cfg_size    = val[5:0];
            REG_SCALE_FACTOR:  cfg_scale   = val[3:0];
            REG_CENTRED:       cfg_centred = val[0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic setup(input logic [10:0] w, input logic [10:0] h, input logic [10:0] ox,
                         input logic [10:0] oy, input logic [10:0] size,
                         input logic [10:0] scale, input logic [10:0] centred);
        write_reg(REG_CANVAS_WIDTH, w);
        write_reg(REG_CANVAS_HEIGHT, h);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_SPRITE_SIZE, size);
        write_reg(REG_SCALE_FACTOR, scale);
        write_reg(REG_CENTRED, centred);
    endtask

    task automatic test_reset_defaults();
        send_color(16'h0000, 1'b1);
        send_color(16'hFFFF, 1'b1);
        send_color(16'h5555, 1'b0);
        send_color(16'hAAAA, 1'b1);
    endtask

    // Block straddles the left and bottom canvas edges.
    task automatic test_clipped_blocks();
        settle_block();
        setup(11'd10, 11'd8, -11'sd3, 11'd5, 11'd2, 11'd4, 11'd0);
        send_color(16'h1234, 1'b1);
        send_color(16'hF800, 1'b1);
        send_color(16'h07E0, 1'b1);
        send_color(16'h001F, 1'b1);
    endtask

    task automatic test_centred_and_corner();
        settle_block();
        // Top-left lands on the last canvas cell: highest address.
        setup(11'd1024, 11'd1024, 11'd1023, 11'd1023, 11'd1, 11'd8, 11'd0);
        send_color(16'hBEEF, 1'b1);
        settle_block();
        setup(11'd1024, 11'd1024, 11'd1023, 11'd1023, 11'd3, 11'd8, 11'd1);
        send_color(16'hCAFE, 1'b1);
        send_color(16'h0F0F, 1'b1);
        send_color(16'hF0F0, 1'b1);
    endtask

    task automatic test_out_of_range_sizes();
        settle_block();
        // Zero sizes act as one.
        setup(11'd0, 11'd2047, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0);
        send_color(16'h8001, 1'b1);
        send_color(16'h7FFE, 1'b1);
        settle_block();
        // Oversized values saturate; origin at its negative extreme.
        setup(11'd2047, 11'd1500, -11'sd1024, 11'd1016, 11'd63, 11'd15, 11'd0);
        send_color(16'h4321, 1'b1);
        send_color(16'hFEDC, 1'b1);
    endtask

    task automatic test_position_wrap();
        settle_block();
        setup(11'd320, 11'd240, 11'd7, 11'd9, 11'd4, 11'd1, 11'd0);
        for (int i = 0; i < 6; i++) send_color(16'(i * 16'h1111), i[0]);
        wait_for_writes();
        settle_block();
        // Shrink the sprite below the stored column: it restarts at zero.
        write_reg(REG_SPRITE_SIZE, 11'd2);
        send_color(16'h0101, 1'b1);
        send_color(16'h0202, 1'b1);
        send_color(16'h0303, 1'b1);
    endtask

    task automatic random_setup();
        logic [10:0] v[7];
        if ($urandom_range(0, 6) == 0) begin
            foreach (v[i]) v[i] = 11'($urandom);
        end else begin
            for (int i = 0; i < 2; i++) begin
                case ($urandom_range(0, 7))
                    0: v[i] = 11'd0;
                    1: v[i] = 11'd1024;
                    2: v[i] = 11'd2047;
                    default: v[i] = 11'($urandom_range(1, 48));
                endcase
            end
            for (int i = 2; i < 4; i++) begin
                if ($urandom_range(0, 9) == 0)
                    v[i] = $urandom_range(0, 1) ? 11'h400 : 11'h3FF;
                else
                    v[i] = 11'($urandom_range(0, 80) - 40);
            end
            case ($urandom_range(0, 11))
                0: v[4] = 11'd0;
                1: v[4] = 11'd32;
                2: v[4] = 11'd63;
                default: v[4] = 11'($urandom_range(1, 6));
            endcase
            v[5] = 11'($urandom_range(0, 15));
            v[6] = 11'($urandom_range(0, 1));
        end
        setup(v[0], v[1], v[2], v[3], v[4], v[5], v[6]);
    endtask

    // Random content, one or two whole sprites or a partial batch for a large sprite, under a fresh setting each phase.
    task automatic test_random_sprites();
        int sent, batch, n;
        pix_in_t px;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            settle_block();
            random_setup();
            gaps_on = ($urandom_range(0, 4) != 0);
            n = clamp_to(int'(cfg_size), SPRITE_MAX);
            batch = (n * n <= 48) ? n * n * $urandom_range(1, 2) : $urandom_range(8, 48);
            for (int i = 0; i < batch; i++) begin
                px.color  = 16'($urandom);
                px.opaque = ($urandom_range(0, 3) != 0);
                send_pixel(px);
                if ($urandom_range(0, 99) == 0) wait_for_writes();
            end
            sent += batch;
        end
        gaps_on = 1'b1;
    endtask

    // Receiver: always ready, mostly ready, mostly stalled, then a fixed duty cycle.
    int sink_cycle = 0;
    always @(posedge aclk) begin
        sink_cycle <= sink_cycle + 1;
        case ((sink_cycle / 256) % 4)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= ((sink_cycle % 16) < 11);
        endcase
    end

    always @(posedge aclk) begin
        pix_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_writes.size() == 0) begin
                report_mismatch("unexpected write, address", int'(m_data.address), 0);
            end else begin
                want = pending_writes.pop_front();
                if (m_data.address !== want.address)
                    report_mismatch("address", int'(m_data.address), int'(want.address));
                if (m_data.pixel !== want.pixel)
                    report_mismatch("pixel", int'(m_data.pixel), int'(want.pixel));
                if (m_data.last !== want.last)
                    report_mismatch("last", int'(m_data.last), int'(want.last));
            end
        end
    end

    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_clipped_blocks();
        test_centred_and_corner();
        test_out_of_range_sizes();
        test_position_wrap();
        test_random_sprites();
        settle_block();
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
